/* rtl/lvc_pkg.sv */
package lvc_pkg;

  // scaling mode codes
  localparam logic [2:0] MODE_NONE       = 3'd0;
  localparam logic [2:0] MODE_STRETCH    = 3'd1;
  localparam logic [2:0] MODE_ASPECT     = 3'd2;
  localparam logic [2:0] MODE_INT_ASPECT = 3'd3;
  localparam logic [2:0] MODE_INT_EXACT  = 3'd4;

  // register indexes (word address)
  localparam logic [1:0] REG_RENDER_W = 2'd0;
  localparam logic [1:0] REG_RENDER_H = 2'd1;
  localparam logic [1:0] REG_MODE     = 2'd2;

  typedef enum logic [3:0] {
    S_IDLE,
    S_DISP,
    S_MUL1,
    S_MUL2,
    S_CMP,
    S_ADIV,
    S_GCD,
    S_GDIV1,
    S_GDIV2,
    S_SDIV1,
    S_SDIV2,
    S_MULW,
    S_MULH,
    S_FIN
  } lvc_state_e;

  typedef struct packed {
    logic start;
    logic wide;
  } lvc_div_req_t;

  typedef struct packed {
    logic busy;
    logic done;
  } lvc_div_sts_t;

endpackage

/* rtl/lvc_div.sv */
module lvc_div import lvc_pkg::*; #(
  parameter int DIM_BITS = 16
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  lvc_div_req_t            req_i,
  input  logic [2*DIM_BITS-1:0]   dividend_i,
  input  logic [DIM_BITS-1:0]     divisor_i,
  output lvc_div_sts_t            sts_o,
  output logic [DIM_BITS-1:0]     quotient_o
);

  localparam int CntW = $clog2(2*DIM_BITS+1);

  logic [DIM_BITS-1:0]   rem_q;
  logic [2*DIM_BITS-1:0] quo_q;
  logic [DIM_BITS-1:0]   dvs_q;
  logic [CntW-1:0]       cnt_q;
  logic                  busy_q;
  logic                  done_q;

  logic [DIM_BITS:0] shifted;
  logic [DIM_BITS:0] diff;
  logic              take;

  // one restoring step per cycle
  assign shifted = {rem_q, quo_q[2*DIM_BITS-1]};
  assign diff    = shifted - {1'b0, dvs_q};
  assign take    = ~diff[DIM_BITS];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (req_i.start && !busy_q) begin
        busy_q <= 1'b1;
        cnt_q  <= req_i.wide ? CntW'(2*DIM_BITS) : CntW'(DIM_BITS);
      end else if (busy_q) begin
        cnt_q <= cnt_q - CntW'(1);
        if (cnt_q == CntW'(1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_i.start && !busy_q) begin
      rem_q <= '0;
      dvs_q <= divisor_i;
      quo_q <= req_i.wide ? dividend_i : {dividend_i[DIM_BITS-1:0], {DIM_BITS{1'b0}}};
    end else if (busy_q) begin
      rem_q <= take ? diff[DIM_BITS-1:0] : shifted[DIM_BITS-1:0];
      quo_q <= {quo_q[2*DIM_BITS-2:0], take};
    end
  end

  assign sts_o.busy = busy_q;
  assign sts_o.done = done_q;
  assign quotient_o = quo_q[DIM_BITS-1:0];

endmodule

/* rtl/letterbox_viewport_calc_top.sv */
// channel   direction  handshake                     payload
// command   in         start & !busy                 window_width_i, window_height_i
// result    out        done_o, one cycle, no stall   view_width_o, view_height_o,
//                                                    offset_x_o, offset_y_o
// config    in         apb, psel&penable&pwrite      render_width, render_height,
//                                                    scaling_mode at 0x0, 0x4, 0x8
//
// from accept, unscaled, stretch, zero render size and unknown mode go straight to finish;
// aspect fit runs one wide restoring division; integer exact runs two narrow divisions;
// integer aspect adds a binary gcd and two more narrow divisions. the shared divider
// yields one quotient bit per cycle. busy stays high for the whole transaction.
// reset clears the sequencer and loads 640 x 480, mode none. the receiver cannot stall.
module letterbox_viewport_calc_top import lvc_pkg::*; #(
  parameter int DIM_BITS = 16
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       start,
  output logic                       busy,
  input  logic [DIM_BITS-1:0]        window_width_i,
  input  logic [DIM_BITS-1:0]        window_height_i,
  output logic                       done_o,
  output logic [DIM_BITS-1:0]        view_width_o,
  output logic [DIM_BITS-1:0]        view_height_o,
  output logic signed [DIM_BITS-1:0] offset_x_o,
  output logic signed [DIM_BITS-1:0] offset_y_o,
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [3:0]                 paddr,
  input  logic [31:0]                pwdata,
  output logic [31:0]                prdata,
  output logic                       pready
);

  localparam int KW = $clog2(DIM_BITS+1);

  lvc_state_e state_q, state_d;

  // configuration registers
  logic [DIM_BITS-1:0] rw_q, rh_q;
  logic [2:0]          mode_q;

  // working registers
  logic [DIM_BITS-1:0]   ww_q, wh_q;
  logic [DIM_BITS-1:0]   vw_q, vh_q;
  logic [DIM_BITS-1:0]   a_q, b_q;
  logic [KW-1:0]         k_q;
  logic [DIM_BITS-1:0]   aw_q, ah_q;
  logic [DIM_BITS-1:0]   s1_q, s_q;
  logic [2*DIM_BITS-1:0] p1_q, p2_q;
  logic                  le_q;

  // result registers
  logic                done_q;
  logic [DIM_BITS-1:0] view_width_q, view_height_q;
  logic [DIM_BITS-1:0] offset_x_q, offset_y_q;

  logic accept;
  logic degenerate;

  // shared multiplier
  logic [DIM_BITS-1:0]   mul_a, mul_b;
  logic [2*DIM_BITS-1:0] prod;

  // shared divider
  lvc_div_req_t          div_req;
  lvc_div_sts_t          div_sts;
  logic [2*DIM_BITS-1:0] div_dividend;
  logic [DIM_BITS-1:0]   div_divisor;
  logic [DIM_BITS-1:0]   div_quot;
  logic                  div_state;

  // final clamp and centering
  logic [DIM_BITS-1:0] vw_c, vh_c;
  logic [DIM_BITS:0]   dx, dy, dx_r, dy_r;
  logic [DIM_BITS-1:0] smin;

  logic cfg_wr;

  assign accept     = start && !busy;
  assign degenerate = (rw_q == '0) || (rh_q == '0);
  assign busy       = (state_q != S_IDLE);

  // ---------------------------------------------------------------- apb port
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rw_q   <= DIM_BITS'(640);
      rh_q   <= DIM_BITS'(480);
      mode_q <= MODE_NONE;
    end else if (cfg_wr) begin
      unique case (paddr[3:2])
        REG_RENDER_W: rw_q   <= pwdata[DIM_BITS-1:0];
        REG_RENDER_H: rh_q   <= pwdata[DIM_BITS-1:0];
        REG_MODE:     mode_q <= pwdata[2:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[3:2])
      REG_RENDER_W: prdata = 32'(rw_q);
      REG_RENDER_H: prdata = 32'(rh_q);
      REG_MODE:     prdata = 32'(mode_q);
      default:      prdata = '0;
    endcase
  end

  // ---------------------------------------------------------------- sequencer
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE: begin
        if (accept) state_d = S_DISP;
      end
      S_DISP: begin
        if (degenerate) begin
          state_d = S_FIN;
        end else begin
          unique case (mode_q)
            MODE_ASPECT:     state_d = S_MUL1;
            MODE_INT_ASPECT: state_d = S_GCD;
            MODE_INT_EXACT:  state_d = S_SDIV1;
            default:         state_d = S_FIN;
          endcase
        end
      end
      S_MUL1:  state_d = S_MUL2;
      S_MUL2:  state_d = S_CMP;
      S_CMP:   state_d = S_ADIV;
      S_ADIV:  if (div_sts.done) state_d = S_FIN;
      S_GCD:   if (a_q == b_q) state_d = S_GDIV1;
      S_GDIV1: if (div_sts.done) state_d = S_GDIV2;
      S_GDIV2: if (div_sts.done) state_d = S_SDIV1;
      S_SDIV1: if (div_sts.done) state_d = S_SDIV2;
      S_SDIV2: if (div_sts.done) state_d = S_MULW;
      S_MULW:  state_d = S_MULH;
      S_MULH:  state_d = S_FIN;
      S_FIN:   state_d = S_IDLE;
      default: state_d = S_IDLE;
    endcase
  end

  // operand selection for the shared units
  always_comb begin
    mul_a        = '0;
    mul_b        = '0;
    div_dividend = '0;
    div_divisor  = '0;
    div_state    = 1'b0;
    div_req.wide = 1'b0;
    unique case (state_q)
      S_MUL1: begin
        mul_a = ww_q;
        mul_b = rh_q;
      end
      S_MUL2: begin
        mul_a = wh_q;
        mul_b = rw_q;
      end
      S_MULW: begin
        mul_a = aw_q;
        mul_b = s_q;
      end
      S_MULH: begin
        mul_a = ah_q;
        mul_b = s_q;
      end
      S_ADIV: begin
        div_state    = 1'b1;
        div_req.wide = 1'b1;
        div_dividend = le_q ? p1_q : p2_q;
        div_divisor  = le_q ? rw_q : rh_q;
      end
      S_GDIV1: begin
        div_state    = 1'b1;
        div_dividend = (2*DIM_BITS)'(rw_q);
        div_divisor  = a_q;
      end
      S_GDIV2: begin
        div_state    = 1'b1;
        div_dividend = (2*DIM_BITS)'(rh_q);
        div_divisor  = a_q;
      end
      S_SDIV1: begin
        div_state    = 1'b1;
        div_dividend = (2*DIM_BITS)'(ww_q);
        div_divisor  = aw_q;
      end
      S_SDIV2: begin
        div_state    = 1'b1;
        div_dividend = (2*DIM_BITS)'(wh_q);
        div_divisor  = ah_q;
      end
      default: ;
    endcase
    // launch once per division state, not in the cycle the previous one lands
    div_req.start = div_state && !div_sts.busy && !div_sts.done;
  end

  assign prod = (2*DIM_BITS)'(mul_a) * (2*DIM_BITS)'(mul_b);

  lvc_div #(
    .DIM_BITS(DIM_BITS)
  ) u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .req_i      (div_req),
    .dividend_i (div_dividend),
    .divisor_i  (div_divisor),
    .sts_o      (div_sts),
    .quotient_o (div_quot)
  );

  // smaller scale factor, at least one
  always_comb begin
    smin = (s1_q < div_quot) ? s1_q : div_quot;
    if (smin == '0) smin = DIM_BITS'(1);
  end

  // ---------------------------------------------------------------- datapath
  always_ff @(posedge clk_i) begin
    unique case (state_q)
      S_IDLE: begin
        if (accept) begin
          ww_q <= window_width_i;
          wh_q <= window_height_i;
        end
      end
      S_DISP: begin
        // zero view falls out as 1 x 1 in the final clamp
        vw_q <= '0;
        vh_q <= '0;
        a_q  <= rw_q;
        b_q  <= rh_q;
        k_q  <= '0;
        aw_q <= rw_q;
        ah_q <= rh_q;
        if (!degenerate) begin
          if (mode_q == MODE_NONE) begin
            vw_q <= rw_q;
            vh_q <= rh_q;
          end else if (mode_q == MODE_STRETCH) begin
            vw_q <= ww_q;
            vh_q <= wh_q;
          end
        end
      end
      S_MUL1: p1_q <= prod;
      S_MUL2: p2_q <= prod;
      S_CMP: begin
        le_q <= (p1_q <= p2_q);
        if (p1_q <= p2_q) begin
          vw_q <= ww_q;
        end else begin
          vh_q <= wh_q;
        end
      end
      S_ADIV: begin
        if (div_sts.done) begin
          if (le_q) begin
            vh_q <= div_quot;
          end else begin
            vw_q <= div_quot;
          end
        end
      end
      S_GCD: begin
        // binary gcd, one shift or subtract per cycle
        priority if (a_q == b_q) begin
          a_q <= a_q << k_q;
        end else if (!a_q[0] && !b_q[0]) begin
          a_q <= a_q >> 1;
          b_q <= b_q >> 1;
          k_q <= k_q + KW'(1);
        end else if (!a_q[0]) begin
          a_q <= a_q >> 1;
        end else if (!b_q[0]) begin
          b_q <= b_q >> 1;
        end else if (a_q > b_q) begin
          a_q <= a_q - b_q;
        end else begin
          b_q <= b_q - a_q;
        end
      end
      S_GDIV1: if (div_sts.done) aw_q <= div_quot;
      S_GDIV2: if (div_sts.done) ah_q <= div_quot;
      S_SDIV1: if (div_sts.done) s1_q <= div_quot;
      S_SDIV2: if (div_sts.done) s_q <= smin;
      S_MULW:  vw_q <= prod[DIM_BITS-1:0];
      S_MULH:  vh_q <= prod[DIM_BITS-1:0];
      default: ;
    endcase
  end

  // ---------------------------------------------------------------- result
  assign vw_c = (vw_q == '0) ? DIM_BITS'(1) : vw_q;
  assign vh_c = (vh_q == '0) ? DIM_BITS'(1) : vh_q;
  assign dx   = {1'b0, ww_q} - {1'b0, vw_c};
  assign dy   = {1'b0, wh_q} - {1'b0, vh_c};
  // halve toward zero: bias negative values by one before the shift
  assign dx_r = dx + (DIM_BITS+1)'(dx[DIM_BITS]);
  assign dy_r = dy + (DIM_BITS+1)'(dy[DIM_BITS]);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      done_q <= 1'b0;
    end else begin
      done_q <= (state_q == S_FIN);
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == S_FIN) begin
      view_width_q  <= vw_c;
      view_height_q <= vh_c;
      offset_x_q    <= dx_r[DIM_BITS:1];
      offset_y_q    <= dy_r[DIM_BITS:1];
    end
  end

  assign done_o        = done_q;
  assign view_width_o  = view_width_q;
  assign view_height_o = view_height_q;
  assign offset_x_o    = offset_x_q;
  assign offset_y_o    = offset_y_q;

  // ---------------------------------------------------------------- checks
  a_view_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> (view_width_o != '0) && (view_height_o != '0))
    else $error("zero view dimension on result");

  a_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> busy)
    else $error("busy not raised after accepted transaction");

  a_done_after_fin: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> $past(state_q == S_FIN))
    else $error("result strobe without finish state");

  a_div_done_state: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_sts.done |-> (state_q == S_ADIV) || (state_q == S_GDIV1) ||
                     (state_q == S_GDIV2) || (state_q == S_SDIV1) ||
                     (state_q == S_SDIV2))
    else $error("divider finished outside a division state");

endmodule
